[src/ctp_pkg.sv]
// Shared types, constants and helper functions of the circle tangent point unit.
package ctp_pkg;

   // Operand widths of the datapath
   localparam int CoordW  = 32;             // Q15.16 coordinate
   localparam int MagW    = 33;             // |p - c|, below 2^32
   localparam int D2W     = 66;             // squared distance
   localparam int R2W     = 62;             // radius squared
   localparam int RootW   = 33;             // floor(sqrt(d2 - r2))
   localparam int RsW     = 64;             // radius * root
   localparam int NumW    = 97;             // dividend of each quotient
   localparam int QuoW    = 34;             // quotient bits resolved by the divider
   localparam int DivLat  = QuoW + 1;       // divider stages plus rounding stage
   localparam int SumW    = 37;             // signed sum before clipping

   localparam logic signed [SumW-1:0] CoordMax = 37'sd2147483647;
   localparam logic signed [SumW-1:0] CoordMin = -37'sd2147483648;

   // Classification code; equals the tangent count reported on the result
   typedef enum logic [1:0] {
      CLS_INSIDE  = 2'd0,
      CLS_ON      = 2'd1,
      CLS_OUTSIDE = 2'd2
   } class_type;

   // Register index of the configuration channel
   typedef enum logic [1:0] {
      REG_CENTER_X  = 2'd0,
      REG_CENTER_Y  = 2'd1,
      REG_RADIUS    = 2'd2,
      REG_TOLERANCE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordW-1:0] center_x;
      logic signed [CoordW-1:0] center_y;
      logic [30:0]              radius;
      logic [31:0]              tolerance;
   } cfg_type;

   // Classified point handed from the front end to the back end
   typedef struct packed {
      class_type                cls;
      logic                     sx;
      logic                     sy;
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;
      logic [MagW-1:0]          ax;
      logic [MagW-1:0]          ay;
      logic [D2W-1:0]           d2;
      logic [D2W-1:0]           excess;
   } item_type;

   // Side data that rides along with the quotients
   typedef struct packed {
      class_type                cls;
      logic                     sx;
      logic                     sy;
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;
   } tag_type;

   // Give a magnitude the sign of its vector component
   function automatic logic signed [SumW-1:0] apply_sign(input logic [QuoW-1:0] mag,
                                                          input logic neg);
      logic signed [SumW-1:0] m;
      m = signed'({3'b000, mag});
      return neg ? -m : m;
   endfunction

   // Clip to the coordinate range; bit 32 flags a clip
   function automatic logic [CoordW:0] clip_coord(input logic signed [SumW-1:0] v);
      logic [CoordW:0] o;
      if (v > CoordMax) begin
         o = {1'b1, 32'h7FFF_FFFF};
      end else if (v < CoordMin) begin
         o = {1'b1, 32'h8000_0000};
      end else begin
         o = {1'b0, v[CoordW-1:0]};
      end
      return o;
   endfunction

endpackage

[src/ctp_if.sv]
// Channel interfaces: query points, tangent results and register writes.
interface ctp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   modport source (output valid, point_x, point_y, input ready);
   modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface ctp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         tangent_count;
   logic signed [31:0] tangent1_x;
   logic signed [31:0] tangent1_y;
   logic signed [31:0] tangent2_x;
   logic signed [31:0] tangent2_y;
   logic               saturated;
   modport source (output valid, tangent_count, tangent1_x, tangent1_y, tangent2_x,
                   tangent2_y, saturated, input ready);
   modport sink   (input valid, tangent_count, tangent1_x, tangent1_y, tangent2_x,
                   tangent2_y, saturated, output ready);
endinterface

interface ctp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[src/ctp_front.sv]
// Front end: takes query points, squares the offset and classifies against the circle.
module ctp_front (
   input  logic                        clock,
   input  logic                        reset,
   ctp_req_if.sink                     req,
   input  ctp_pkg::cfg_type            cfg,
   input  logic                        q_full,
   output logic                        push,
   output ctp_pkg::item_type           push_item,
   output logic [ctp_pkg::R2W-1:0]     r2
);

   logic front_adv;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [31:0]       px1_ff, py1_ff, px2_ff, py2_ff, px3_ff, py3_ff, px4_ff, py4_ff;
   logic signed [32:0]       vx1_ff, vy1_ff, vx_in, vy_in;
   logic                     sx2_ff, sy2_ff, sx3_ff, sy3_ff, sx4_ff, sy4_ff;
   logic [32:0]              ax2_ff, ay2_ff, ax3_ff, ay3_ff, ax4_ff, ay4_ff, ax_in, ay_in;
   logic [65:0]              sqx3_ff, sqy3_ff, sqx_in, sqy_in, d2_4_ff, d2_in;
   logic [ctp_pkg::R2W-1:0]  r2_ff, r2_in;

   logic [62:0] hi_lim;
   logic [66:0] d2_plus;
   logic        on_circle, below;

   // Advance all stages together unless the last one is blocked by a full queue
   assign front_adv = !v4_ff || !q_full;
   assign req.ready = front_adv;
   assign push      = v4_ff && !q_full;

   // Radius squared follows the register
   assign r2_in = cfg.radius * cfg.radius;
   assign r2    = r2_ff;

   always_ff @(posedge clock) begin
      r2_ff <= r2_in;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (front_adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Offset from the center, magnitude, squares, squared distance
   assign vx_in  = {req.point_x[31], req.point_x} - {cfg.center_x[31], cfg.center_x};
   assign vy_in  = {req.point_y[31], req.point_y} - {cfg.center_y[31], cfg.center_y};
   assign ax_in  = vx1_ff[32] ? -vx1_ff : vx1_ff;
   assign ay_in  = vy1_ff[32] ? -vy1_ff : vy1_ff;
   assign sqx_in = ax2_ff * ax2_ff;
   assign sqy_in = ay2_ff * ay2_ff;
   assign d2_in  = sqx3_ff + sqy3_ff;

   always_ff @(posedge clock) begin
      if (front_adv) begin
         px1_ff  <= req.point_x;
         py1_ff  <= req.point_y;
         vx1_ff  <= vx_in;
         vy1_ff  <= vy_in;
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         sx2_ff  <= vx1_ff[32];
         sy2_ff  <= vy1_ff[32];
         ax2_ff  <= ax_in;
         ay2_ff  <= ay_in;
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         sqx3_ff <= sqx_in;
         sqy3_ff <= sqy_in;
         px4_ff  <= px3_ff;
         py4_ff  <= py3_ff;
         sx4_ff  <= sx3_ff;
         sy4_ff  <= sy3_ff;
         ax4_ff  <= ax3_ff;
         ay4_ff  <= ay3_ff;
         d2_4_ff <= d2_in;
      end
   end

   // Classify: on the circle within tolerance, inside, or outside
   assign hi_lim    = {1'b0, r2_ff} + {31'b0, cfg.tolerance};
   assign d2_plus   = {1'b0, d2_4_ff} + {35'b0, cfg.tolerance};
   assign on_circle = ({1'b0, d2_4_ff} <= {4'b0, hi_lim}) && ({5'b0, r2_ff} <= d2_plus);
   assign below     = d2_4_ff < {4'b0, r2_ff};

   always_comb begin
      push_item.sx     = sx4_ff;
      push_item.sy     = sy4_ff;
      push_item.px     = px4_ff;
      push_item.py     = py4_ff;
      push_item.ax     = ax4_ff;
      push_item.ay     = ay4_ff;
      push_item.d2     = d2_4_ff;
      push_item.excess = d2_4_ff - {4'b0, r2_ff};
      if (on_circle) begin
         push_item.cls = ctp_pkg::CLS_ON;
      end else if (below) begin
         push_item.cls = ctp_pkg::CLS_INSIDE;
      end else begin
         push_item.cls = ctp_pkg::CLS_OUTSIDE;
      end
   end

endmodule

[src/ctp_fifo.sv]
// Short queue of classified points between the front end and the back end.
module ctp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ctp_pkg::item_type push_data,
   output logic              full,
   input  logic              pop,
   output ctp_pkg::item_type pop_data,
   output logic              empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   ctp_pkg::item_type mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full     = count_ff == CntW'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   assign wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CntW'(DEPTH)))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

[src/ctp_div.sv]
// Pipelined restoring divider with round-to-nearest, one quotient bit per stage.
module ctp_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [ctp_pkg::NumW-1:0]   num,
   input  logic [ctp_pkg::D2W-1:0]    den,
   output logic [ctp_pkg::QuoW-1:0]   quo
);

   localparam int QW = ctp_pkg::QuoW;
   localparam int DW = ctp_pkg::D2W;
   localparam int NW = ctp_pkg::NumW;

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff;
   logic [DW:0]   dbl_rem;
   logic          round_up;

   // The quotient fits in QW bits, so the dividend's upper part is below the divisor
   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DW-1:0] rem_prev, den_prev;
      logic [QW-1:0] q_prev, lo_prev;
      logic [DW:0]   trial, diff;
      logic          fits;

      if (i == 0) begin : g_head
         assign rem_prev = {{(DW - (NW - QW)){1'b0}}, num[NW-1:QW]};
         assign q_prev   = '0;
         assign lo_prev  = num[QW-1:0];
         assign den_prev = den;
      end else begin : g_tail
         assign rem_prev = rem_ff[i-1];
         assign q_prev   = q_ff[i-1];
         assign lo_prev  = lo_ff[i-1];
         assign den_prev = den_ff[i-1];
      end

      assign trial = {rem_prev, lo_prev[QW-1-i]};
      assign fits  = trial >= {1'b0, den_prev};
      assign diff  = trial - {1'b0, den_prev};

      // Shift each new quotient bit in at the bottom, most significant first
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= fits ? diff[DW-1:0] : trial[DW-1:0];
            q_ff[i]   <= {q_prev[QW-2:0], fits};
            lo_ff[i]  <= lo_prev;
            den_ff[i] <= den_prev;
         end
      end
   end

   // Round half up on the final remainder
   assign dbl_rem  = {rem_ff[QW-1], 1'b0};
   assign round_up = dbl_rem >= {1'b0, den_ff[QW-1]};

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= q_ff[QW-1] + {{(QW - 1){1'b0}}, round_up};
      end
   end

   assign quo = quo_ff;

endmodule

[src/ctp_back.sv]
// Back end: square root, products, four quotients, sums with clipping and ordering.
module ctp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  ctp_pkg::item_type        q_data,
   output logic                     pop,
   input  ctp_pkg::cfg_type         cfg,
   input  logic [ctp_pkg::R2W-1:0]  r2,
   ctp_rsp_if.source                rsp
);

   localparam int SqStages = ctp_pkg::RootW;
   localparam int DL       = ctp_pkg::DivLat;

   logic back_adv;
   logic out_valid_ff;

   assign back_adv  = !out_valid_ff || rsp.ready;
   assign pop       = back_adv && !q_empty;
   assign rsp.valid = out_valid_ff;

   // Square root of the excess, one root bit per stage
   logic              sq_valid_ff [SqStages];
   ctp_pkg::item_type sq_item_ff  [SqStages];
   logic [65:0]       sq_rem_ff   [SqStages];
   logic [32:0]       sq_root_ff  [SqStages];

   for (genvar k = 0; k < SqStages; k++) begin : g_sqrt
      localparam int B = SqStages - 1 - k;
      logic              v_prev;
      ctp_pkg::item_type i_prev;
      logic [65:0]       r_prev;
      logic [32:0]       o_prev;
      logic [67:0]       trial, diff;
      logic              fits;

      if (k == 0) begin : g_head
         assign v_prev = !q_empty;
         assign i_prev = q_data;
         assign r_prev = q_data.excess;
         assign o_prev = '0;
      end else begin : g_tail
         assign v_prev = sq_valid_ff[k-1];
         assign i_prev = sq_item_ff[k-1];
         assign r_prev = sq_rem_ff[k-1];
         assign o_prev = sq_root_ff[k-1];
      end

      assign trial = ({35'b0, o_prev} << (B + 1)) | (68'b1 << (2 * B));
      assign fits  = {2'b00, r_prev} >= trial;
      assign diff  = {2'b00, r_prev} - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (back_adv) begin
            sq_valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (back_adv) begin
            sq_item_ff[k] <= i_prev;
            sq_rem_ff[k]  <= fits ? diff[65:0] : r_prev;
            sq_root_ff[k] <= fits ? (o_prev | (33'b1 << B)) : o_prev;
         end
      end
   end

   ctp_pkg::item_type sq_last;
   ctp_pkg::tag_type  sq_tag;
   assign sq_last = sq_item_ff[SqStages-1];

   always_comb begin
      sq_tag.cls = sq_last.cls;
      sq_tag.sx  = sq_last.sx;
      sq_tag.sy  = sq_last.sy;
      sq_tag.px  = sq_last.px;
      sq_tag.py  = sq_last.py;
   end

   // First product stage: r * root and the halves of r^2 times each magnitude
   logic             m1_valid_ff;
   ctp_pkg::tag_type m1_tag_ff;
   logic [32:0]      m1_ax_ff, m1_ay_ff;
   logic [65:0]      m1_d2_ff;
   logic [63:0]      m1_rs_ff, m1_pax_lo_ff, m1_pax_hi_ff, m1_pay_lo_ff, m1_pay_hi_ff;
   logic [63:0]      rs_in, pax_lo_in, pax_hi_in, pay_lo_in, pay_hi_in;

   assign rs_in     = cfg.radius * sq_root_ff[SqStages-1];
   assign pax_lo_in = r2[30:0] * sq_last.ax;
   assign pax_hi_in = r2[61:31] * sq_last.ax;
   assign pay_lo_in = r2[30:0] * sq_last.ay;
   assign pay_hi_in = r2[61:31] * sq_last.ay;

   always_ff @(posedge clock) begin
      if (back_adv) begin
         m1_tag_ff    <= sq_tag;
         m1_ax_ff     <= sq_last.ax;
         m1_ay_ff     <= sq_last.ay;
         m1_d2_ff     <= sq_last.d2;
         m1_rs_ff     <= rs_in;
         m1_pax_lo_ff <= pax_lo_in;
         m1_pax_hi_ff <= pax_hi_in;
         m1_pay_lo_ff <= pay_lo_in;
         m1_pay_hi_ff <= pay_hi_in;
      end
   end

   // Second product stage: join r^2 halves, split r * root across each magnitude
   logic             m2_valid_ff;
   ctp_pkg::tag_type m2_tag_ff;
   logic [65:0]      m2_d2_ff;
   logic [96:0]      m2_num_ax_ff, m2_num_ay_ff, num_ax_in, num_ay_in;
   logic [64:0]      m2_pbx_lo_ff, m2_pbx_hi_ff, m2_pby_lo_ff, m2_pby_hi_ff;
   logic [64:0]      pbx_lo_in, pbx_hi_in, pby_lo_in, pby_hi_in;

   assign num_ax_in = (97'(m1_pax_hi_ff) << 31) + 97'(m1_pax_lo_ff);
   assign num_ay_in = (97'(m1_pay_hi_ff) << 31) + 97'(m1_pay_lo_ff);
   assign pbx_lo_in = m1_rs_ff[31:0] * m1_ay_ff;
   assign pbx_hi_in = m1_rs_ff[63:32] * m1_ay_ff;
   assign pby_lo_in = m1_rs_ff[31:0] * m1_ax_ff;
   assign pby_hi_in = m1_rs_ff[63:32] * m1_ax_ff;

   always_ff @(posedge clock) begin
      if (back_adv) begin
         m2_tag_ff    <= m1_tag_ff;
         m2_d2_ff     <= m1_d2_ff;
         m2_num_ax_ff <= num_ax_in;
         m2_num_ay_ff <= num_ay_in;
         m2_pbx_lo_ff <= pbx_lo_in;
         m2_pbx_hi_ff <= pbx_hi_in;
         m2_pby_lo_ff <= pby_lo_in;
         m2_pby_hi_ff <= pby_hi_in;
      end
   end

   // Third product stage: join the r * root partial products
   logic             m3_valid_ff;
   ctp_pkg::tag_type m3_tag_ff;
   logic [65:0]      m3_d2_ff;
   logic [96:0]      m3_num_ax_ff, m3_num_ay_ff, m3_num_bx_ff, m3_num_by_ff;
   logic [96:0]      num_bx_in, num_by_in;

   assign num_bx_in = (97'(m2_pbx_hi_ff) << 32) + 97'(m2_pbx_lo_ff);
   assign num_by_in = (97'(m2_pby_hi_ff) << 32) + 97'(m2_pby_lo_ff);

   always_ff @(posedge clock) begin
      if (back_adv) begin
         m3_tag_ff    <= m2_tag_ff;
         m3_d2_ff     <= m2_d2_ff;
         m3_num_ax_ff <= m2_num_ax_ff;
         m3_num_ay_ff <= m2_num_ay_ff;
         m3_num_bx_ff <= num_bx_in;
         m3_num_by_ff <= num_by_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (back_adv) begin
         m1_valid_ff <= sq_valid_ff[SqStages-1];
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
   end

   // Four quotients by the squared distance
   logic [ctp_pkg::QuoW-1:0] q_ax, q_ay, q_bx, q_by;

   ctp_div u_div_ax (.clock(clock), .en(back_adv), .num(m3_num_ax_ff), .den(m3_d2_ff),
                     .quo(q_ax));
   ctp_div u_div_ay (.clock(clock), .en(back_adv), .num(m3_num_ay_ff), .den(m3_d2_ff),
                     .quo(q_ay));
   ctp_div u_div_bx (.clock(clock), .en(back_adv), .num(m3_num_bx_ff), .den(m3_d2_ff),
                     .quo(q_bx));
   ctp_div u_div_by (.clock(clock), .en(back_adv), .num(m3_num_by_ff), .den(m3_d2_ff),
                     .quo(q_by));

   // Carry the side data alongside the divider stages
   logic             dv_valid_ff [DL];
   ctp_pkg::tag_type dv_tag_ff   [DL];

   for (genvar j = 0; j < DL; j++) begin : g_dtag
      if (j == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[j] <= 1'b0;
            end else if (back_adv) begin
               dv_valid_ff[j] <= m3_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (back_adv) begin
               dv_tag_ff[j] <= m3_tag_ff;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[j] <= 1'b0;
            end else if (back_adv) begin
               dv_valid_ff[j] <= dv_valid_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            if (back_adv) begin
               dv_tag_ff[j] <= dv_tag_ff[j-1];
            end
         end
      end
   end

   // Sum stage: center plus signed quotients, clipped to the coordinate range
   ctp_pkg::tag_type              dv_tag;
   logic signed [ctp_pkg::SumW-1:0] sax, say, sbx, sby, cxe, cye;
   logic signed [ctp_pkg::SumW-1:0] x1_sum, y1_sum, x2_sum, y2_sum;
   logic [32:0]                   x1_clip, y1_clip, x2_clip, y2_clip;

   assign dv_tag = dv_tag_ff[DL-1];
   assign sax    = ctp_pkg::apply_sign(q_ax, dv_tag.sx);
   assign say    = ctp_pkg::apply_sign(q_ay, dv_tag.sy);
   assign sbx    = ctp_pkg::apply_sign(q_bx, dv_tag.sy);
   assign sby    = ctp_pkg::apply_sign(q_by, dv_tag.sx);
   assign cxe    = {{5{cfg.center_x[31]}}, cfg.center_x};
   assign cye    = {{5{cfg.center_y[31]}}, cfg.center_y};
   assign x1_sum = cxe + sax - sbx;
   assign y1_sum = cye + say + sby;
   assign x2_sum = cxe + sax + sbx;
   assign y2_sum = cye + say - sby;
   assign x1_clip = ctp_pkg::clip_coord(x1_sum);
   assign y1_clip = ctp_pkg::clip_coord(y1_sum);
   assign x2_clip = ctp_pkg::clip_coord(x2_sum);
   assign y2_clip = ctp_pkg::clip_coord(y2_sum);

   logic               s_valid_ff;
   ctp_pkg::tag_type   s_tag_ff;
   logic signed [31:0] s_x1_ff, s_y1_ff, s_x2_ff, s_y2_ff;
   logic               s_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (back_adv) begin
         s_valid_ff <= dv_valid_ff[DL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (back_adv) begin
         s_tag_ff <= dv_tag;
         s_x1_ff  <= x1_clip[31:0];
         s_y1_ff  <= y1_clip[31:0];
         s_x2_ff  <= x2_clip[31:0];
         s_y2_ff  <= y2_clip[31:0];
         s_sat_ff <= x1_clip[32] | y1_clip[32] | x2_clip[32] | y2_clip[32];
      end
   end

   // Output stage: select by class, put the larger x (then larger y) first
   logic [1:0]         count_ff, count_in;
   logic signed [31:0] t1x_ff, t1y_ff, t2x_ff, t2y_ff, t1x_in, t1y_in, t2x_in, t2y_in;
   logic               sat_ff, sat_in, swap;

   assign swap = (s_x2_ff > s_x1_ff) || ((s_x2_ff == s_x1_ff) && (s_y2_ff > s_y1_ff));

   always_comb begin
      count_in = s_tag_ff.cls;
      t1x_in   = '0;
      t1y_in   = '0;
      t2x_in   = '0;
      t2y_in   = '0;
      sat_in   = 1'b0;
      unique case (s_tag_ff.cls)
         ctp_pkg::CLS_ON: begin
            t1x_in = s_tag_ff.px;
            t1y_in = s_tag_ff.py;
            t2x_in = s_tag_ff.px;
            t2y_in = s_tag_ff.py;
         end
         ctp_pkg::CLS_OUTSIDE: begin
            t1x_in = swap ? s_x2_ff : s_x1_ff;
            t1y_in = swap ? s_y2_ff : s_y1_ff;
            t2x_in = swap ? s_x1_ff : s_x2_ff;
            t2y_in = swap ? s_y1_ff : s_y2_ff;
            sat_in = s_sat_ff;
         end
         default: begin
            count_in = ctp_pkg::CLS_INSIDE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (back_adv) begin
         out_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_adv) begin
         count_ff <= count_in;
         t1x_ff   <= t1x_in;
         t1y_ff   <= t1y_in;
         t2x_ff   <= t2x_in;
         t2y_ff   <= t2y_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp.tangent_count = count_ff;
   assign rsp.tangent1_x    = t1x_ff;
   assign rsp.tangent1_y    = t1y_ff;
   assign rsp.tangent2_x    = t2x_ff;
   assign rsp.tangent2_y    = t2y_ff;
   assign rsp.saturated     = sat_ff;

`ifndef SYNTH
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && count_ff == ctp_pkg::CLS_INSIDE) |->
         (t1x_ff == 0 && t1y_ff == 0 && t2x_ff == 0 && t2y_ff == 0 && !sat_ff))
      else $error("inside result carries nonzero points");
   a_on_same: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && count_ff == ctp_pkg::CLS_ON) |->
         (t1x_ff == t2x_ff && t1y_ff == t2y_ff && !sat_ff))
      else $error("on-circle result points differ");
   a_order: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && count_ff == ctp_pkg::CLS_OUTSIDE) |->
         ((t1x_ff > t2x_ff) || (t1x_ff == t2x_ff && t1y_ff >= t2y_ff)))
      else $error("tangent points out of order");
`endif

endmodule

[src/circle_tangent_points_unit.sv]
// Top level of the circle tangent point unit: registers, front end, queue, back end.
//
//   channel  | dir | payload                                        | transaction
//   ---------+-----+------------------------------------------------+-----------------
//   req_if   | in  | point_x, point_y                               | valid & ready
//   rsp_if   | out | tangent_count, tangent1/2_x/y, saturated       | valid & ready
//   csr_if   | in  | index, wdata                                   | valid & ready
//
// One point per cycle sustained while the result channel is not stalled. The path runs
// through 4 front stages, the queue, 33 root stages, 3 product stages, 35 divider stages, sum and output.
// The per-bit root and divider stages set the latency.
// Reset is synchronous: it empties all stages and the queue and restores the registers.
// An output stall holds the back end; the front end keeps taking points until the queue
// fills. The register port is always ready.
module circle_tangent_points_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   ctp_req_if.sink    req_if,
   ctp_rsp_if.source  rsp_if,
   ctp_csr_if.sink    csr_if
);

   ctp_pkg::cfg_type  cfg_ff;
   ctp_pkg::item_type push_item, pop_item;
   logic              push, pop, q_full, q_empty;
   logic [ctp_pkg::R2W-1:0] r2;

   // Register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x  <= '0;
         cfg_ff.center_y  <= '0;
         cfg_ff.radius    <= 31'd65536;
         cfg_ff.tolerance <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            ctp_pkg::REG_CENTER_X:  cfg_ff.center_x  <= csr_if.wdata;
            ctp_pkg::REG_CENTER_Y:  cfg_ff.center_y  <= csr_if.wdata;
            ctp_pkg::REG_RADIUS:    cfg_ff.radius    <= csr_if.wdata[30:0];
            ctp_pkg::REG_TOLERANCE: cfg_ff.tolerance <= csr_if.wdata;
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   ctp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item),
      .r2        (r2)
   );

   ctp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_item),
      .empty     (q_empty)
   );

   ctp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (pop_item),
      .pop     (pop),
      .cfg     (cfg_ff),
      .r2      (r2),
      .rsp     (rsp_if)
   );

endmodule

[bench/circle_tangent_points_unit_tb.sv]
// Self-checking testbench of the circle tangent point unit with a scoreboard class.
module circle_tangent_points_unit_tb;

   localparam int  ClockPeriod = 12;
   localparam int  CycleLimit  = 2000000;
   localparam int  Drain       = 120;

   typedef struct packed {
      logic [1:0]         count;
      logic signed [31:0] t1x;
      logic signed [31:0] t1y;
      logic signed [31:0] t2x;
      logic signed [31:0] t2y;
      logic               sat;
   } tangent_type;

   // Scoreboard: predicts tangent points and checks results in order
   class tangent_scoreboard;
      logic signed [31:0] cx, cy;
      logic [30:0]        rad;
      logic [31:0]        tol;
      tangent_type        pending_q[$];
      int                 mismatches;

      function new();
         cx = 0; cy = 0; rad = 31'd65536; tol = 0;
         mismatches = 0;
      endfunction

      function void write_reg(ctp_pkg::csr_index_type idx, logic [31:0] v);
         case (idx)
            ctp_pkg::REG_CENTER_X:  cx = v;
            ctp_pkg::REG_CENTER_Y:  cy = v;
            ctp_pkg::REG_RADIUS:    rad = v[30:0];
            ctp_pkg::REG_TOLERANCE: tol = v;
            default: ;
         endcase
      endfunction

      // Round-to-nearest quotient, halves up
      function logic [63:0] div_round(logic [129:0] n, logic [129:0] d);
         logic [129:0] q, r;
         if (d == 0) return 0;
         q = n / d;
         r = n % d;
         if ((r << 1) >= d) q = q + 1;
         return q[63:0];
      endfunction

      function logic [33:0] floor_root(logic [65:0] x);
         logic [33:0] res, cand;
         logic [67:0] sq;
         res = 0;
         for (int b = 33; b >= 0; b--) begin
            cand = res | (34'd1 << b);
            sq = {34'd0, cand} * {34'd0, cand};
            if (sq <= {2'b00, x}) res = cand;
         end
         return res;
      endfunction

      function logic signed [63:0] signed_mag(logic [63:0] m, logic neg);
         return neg ? -$signed(m) : $signed(m);
      endfunction

      function logic signed [31:0] clip(logic signed [63:0] v, inout logic flag);
         if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
         end
         if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h8000_0000;
         end
         return v[31:0];
      endfunction

      function tangent_type predict(logic signed [31:0] px, logic signed [31:0] py);
         tangent_type t;
         logic signed [63:0] vx, vy, sx1, sy1, sx2, sy2;
         logic signed [63:0] aq, ayq, bq, byq;
         logic [63:0]  ax, ay, rs;
         logic [65:0]  d2, r2, tl;
         logic [33:0]  s;
         logic signed [31:0] tmp;
         logic         flag;
         t = '0;
         flag = 1'b0;
         vx = 64'(px) - 64'(cx);
         vy = 64'(py) - 64'(cy);
         ax = vx < 0 ? -vx : vx;
         ay = vy < 0 ? -vy : vy;
         d2 = 66'(ax * ax) + 66'(ay * ay);
         r2 = 66'({33'd0, rad} * {33'd0, rad});
         tl = 66'(tol);
         if (d2 <= r2 + tl && r2 <= d2 + tl) begin
            t.count = ctp_pkg::CLS_ON;
            t.t1x = px; t.t1y = py; t.t2x = px; t.t2y = py;
         end else if (d2 < r2) begin
            t.count = ctp_pkg::CLS_INSIDE;
         end else begin
            s  = floor_root(d2 - r2);
            rs = 64'(rad) * 64'(s);
            aq  = signed_mag(div_round(130'(r2) * 130'(ax), 130'(d2)), vx < 0);
            ayq = signed_mag(div_round(130'(r2) * 130'(ay), 130'(d2)), vy < 0);
            bq  = signed_mag(div_round(130'(rs) * 130'(ay), 130'(d2)), vy < 0);
            byq = signed_mag(div_round(130'(rs) * 130'(ax), 130'(d2)), vx < 0);
            sx1 = 64'(cx) + aq - bq;
            sy1 = 64'(cy) + ayq + byq;
            sx2 = 64'(cx) + aq + bq;
            sy2 = 64'(cy) + ayq - byq;
            t.count = ctp_pkg::CLS_OUTSIDE;
            t.t1x = clip(sx1, flag);
            t.t1y = clip(sy1, flag);
            t.t2x = clip(sx2, flag);
            t.t2y = clip(sy2, flag);
            // Larger x first, then larger y
            if (t.t2x > t.t1x || (t.t2x == t.t1x && t.t2y > t.t1y)) begin
               tmp = t.t1x; t.t1x = t.t2x; t.t2x = tmp;
               tmp = t.t1y; t.t1y = t.t2y; t.t2y = tmp;
            end
            t.sat = flag;
         end
         return t;
      endfunction

      function void note_point(logic signed [31:0] px, logic signed [31:0] py);
         pending_q.push_back(predict(px, py));
      endfunction

      function void check_result(tangent_type got);
         tangent_type exp_t;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         exp_t = pending_q.pop_front();
         if (got !== exp_t) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_t, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   ctp_req_if req_if();
   ctp_rsp_if rsp_if();
   ctp_csr_if csr_if();

   circle_tangent_points_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   tangent_scoreboard tangents;
   int                cycles;
   int                points_taken;
   bit                long_hold_done;
   int                hold_left;
   int                stall_mode;

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Watch both channels and feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            tangents.note_point(req_if.point_x, req_if.point_y);
            points_taken <= points_taken + 1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            tangents.check_result({rsp_if.tangent_count, rsp_if.tangent1_x,
                                   rsp_if.tangent1_y, rsp_if.tangent2_x,
                                   rsp_if.tangent2_y, rsp_if.saturated});
         end
      end
   end

   // Stall the result channel; hold off once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!long_hold_done && points_taken >= 400) begin
         long_hold_done <= 1'b1;
         hold_left <= 300;
         rsp_if.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= cycles[2];
         endcase
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   int burst_left;

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         // Drop valid only when a real gap follows
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_if.valid   <= 1'b1;
      req_if.point_x <= x;
      req_if.point_y <= y;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tangents.pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(ctp_pkg::csr_index_type idx, logic [31:0] v);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      tangents.write_reg(idx, v);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_circle(logic [31:0] x, logic [31:0] y, logic [31:0] r, logic [31:0] t);
      wait_idle();
      write_csr(ctp_pkg::REG_CENTER_X, x);
      write_csr(ctp_pkg::REG_CENTER_Y, y);
      write_csr(ctp_pkg::REG_RADIUS, r);
      write_csr(ctp_pkg::REG_TOLERANCE, t);
   endtask

   function automatic logic signed [31:0] clamp(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Random point: mostly near the circle, some full-range noise
   task automatic send_random_point();
      logic signed [63:0] r, ox, oy, jit;
      int kind;
      r = 64'(tangents.rad);
      kind = $urandom_range(0, 9);
      jit = $signed(64'($urandom_range(0, 8))) - 4;
      case (kind)
         0, 1: begin
            send_point($urandom, $urandom);
         end
         2, 3: begin
            // On or just off the circle along an axis
            ox = ($urandom_range(0, 1) ? r : -r) + jit;
            if ($urandom_range(0, 1)) send_point(clamp(64'(tangents.cx) + ox), tangents.cy);
            else send_point(tangents.cx, clamp(64'(tangents.cy) + ox));
         end
         4, 5, 6: begin
            // Within about three radii of the center on each axis; mostly outside
            ox = (r + 1) * $signed(64'($urandom_range(0, 6))) - 3 * r
                 + $signed(64'($urandom_range(0, 65535)));
            oy = (r + 1) * $signed(64'($urandom_range(0, 6))) - 3 * r
                 + $signed(64'($urandom_range(0, 65535)));
            send_point(clamp(64'(tangents.cx) + ox), clamp(64'(tangents.cy) + oy));
         end
         default: begin
            // Inside
            ox = (r == 0) ? 0 : $signed(64'($urandom) % (r + 1)) - r / 2;
            oy = (r == 0) ? 0 : $signed(64'($urandom) % (r + 1)) - r / 2;
            send_point(clamp(64'(tangents.cx) + ox), clamp(64'(tangents.cy) + oy));
         end
      endcase
   endtask

   task automatic random_phase(int n);
      repeat (n) send_random_point();
   endtask

   initial begin
      tangents = new();
      cycles = 0;
      points_taken = 0;
      long_hold_done = 1'b0;
      hold_left = 0;
      stall_mode = 0;
      burst_left = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      csr_if.valid = 1'b0;
      csr_if.index = ctp_pkg::REG_CENTER_X;
      csr_if.wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points against the reset circle
      send_point(0, 0);
      send_point(32'sd65536, 0);
      send_point(0, -32'sd65536);
      send_point(32'sd131072, 0);
      send_point(0, 32'sd131072);
      send_point(32'sd131072, 32'sd131072);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 0);
      send_point(32'sd65535, 0);
      send_point(32'sd65537, 0);
      // Extreme center, huge radius, full tolerance; saturating outputs
      set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(0, 0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h8000_0000);
      // Zero radius
      set_circle(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 0);
      send_point(32'h0001_0000, 32'hFFFF_0000);
      send_point(32'h0003_0000, 32'hFFFF_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_phase(60);

      set_circle(0, 0, 32'd65536, 0);
      random_phase(150);
      set_circle($urandom_range(0, 32'h00FF_FFFF), -$urandom_range(0, 32'h00FF_FFFF),
                 32'h0005_0000, 32'h0001_0000);
      random_phase(250);
      // Let the pipeline drain completely while the sender pauses
      wait_idle();
      random_phase(100);
      set_circle($urandom, $urandom, $urandom, $urandom);
      random_phase(150);
      set_circle(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(1, 32'h0100_0000),
                 32'hFFFF_FFFF);
      random_phase(150);
      set_circle(0, $urandom, 32'h7FFF_FFFF, 0);
      random_phase(100);
      set_circle($urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFFFF),
                 $urandom_range(1, 32'h0002_0000), $urandom_range(0, 32'hFFFF));
      random_phase(200);
      set_circle(0, 0, 32'd0, 32'd0);
      random_phase(50);

      wait_idle();
      repeat (Drain) @(posedge clock);
      if (tangents.mismatches == 0 && tangents.pending_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/ctp_pkg.sv
src/ctp_if.sv
src/ctp_front.sv
src/ctp_fifo.sv
src/ctp_div.sv
src/ctp_back.sv
src/circle_tangent_points_unit.sv
bench/circle_tangent_points_unit_tb.sv
